>>> rtl/bfha_pkg.sv
// ----------------------------------------------------------------------------
// bfha_pkg: shared types and constants of the best-fit heap allocator
// Chunk map word layout, status codes, result codes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bfha_pkg;

  localparam int unsigned MAP_DEPTH = 16384;  // heap words of 4 bytes
  localparam int unsigned ADDR_W    = 14;
  localparam int unsigned SZW       = 15;     // chunk size in words
  localparam int unsigned CNT_W     = 14;
  localparam int unsigned HDR_WORDS = 2;      // 8-byte header
  localparam int unsigned SPLIT_WORDS = 8;    // 32 spare bytes
  localparam logic [SZW-1:0] MIN_HEAP_W = 15'd1024;
  localparam logic [SZW-1:0] MAX_HEAP_W = 15'd16384;
  localparam logic [CNT_W-1:0] MAX_FREE = 14'd8192;

  // chunk status stored with each chunk start
  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_FREE  = 2'd1;
  localparam logic [1:0] ST_ALLOC = 2'd2;

  // result codes
  localparam logic [1:0] RC_OK    = 2'd0;
  localparam logic [1:0] RC_NOFIT = 2'd1;
  localparam logic [1:0] RC_ZERO  = 2'd2;
  localparam logic [1:0] RC_BAD   = 2'd3;

  localparam logic OP_ALLOC = 1'b0;

  typedef enum logic [3:0] {
    CMD_NOP, CMD_FORMAT, CMD_LOAD, CMD_RD_OFF, CMD_STEP, CMD_RD_NXT,
    CMD_LATCH_NXT, CMD_WR_A, CMD_WR_B, CMD_FINISH
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [1:0] code;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic zero_size;
    logic bad_early;
    logic walk_end;
    logic past_tgt;
    logic hit_exact;
    logic found;
    logic tgt_alloc;
    logic have_best;
    logic split;
    logic out_busy;
  } dp_status_t;

endpackage

>>> rtl/best_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_core: best-fit heap allocator, split and coalesce
// Manages a heap of 8-byte-header chunks; serves allocate and free requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per handshake. in_tuser = op (0 allocate, 1 free).
//   out_* : one result per request, held in an output register.
//   cfg_* : heap size write; accepted only between requests, it reformats
//           the heap to a single free chunk and drops every allocation.
// Walk: a request walks chunk headers in address order, each header taking
//   one map read plus its registered data. Allocate walks every chunk
//   unless an exact fit stops it early, with one more map write when the
//   chosen chunk is split; free walks the chunks before it.
//   The single read port of the chunk map sets the pace of the walk.
// Throughput: one request at a time; the next is taken once the result is
//   in the output register, even if the receiver has not taken it yet.
// Reset: synchronous, active low; after reset the S_INIT state formats the map
//   to a single 4096-byte free chunk and the block then takes requests.
// Stall: with out_tready low the result holds; a second finished result
//   waits inside until the register frees.
module best_fit_heap_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // req_size[15:0], data_offset[31:16]
  input  logic [0:0]  in_tuser,   // op[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // payload_offset[15:0], chunk_bytes[32:16],
                                  // free_chunks[46:33], zero fill [47]
  output logic [1:0]  out_tuser,  // result_code[1:0]
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [23:0] cfg_tdata   // heap_bytes[16:0], zero fill [23:17]
);

  bfha_pkg::ctl_cmd_t   cmd;
  bfha_pkg::dp_status_t status;

  // sequencer
  bfha_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // map, arithmetic and result register
  bfha_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_tvalid && cfg_tready),
    .cfg_data   (cfg_tdata[16:0]),
    .cmd        (cmd),
    .status     (status),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> rtl/bfha_ctrl.sv
// ----------------------------------------------------------------------------
// bfha_ctrl: request sequencer of the allocator
// Walks the chunk map through the datapath header by header, with a read
// state and an evaluate state per header, and finishes with the map update and the result.
// ----------------------------------------------------------------------------
module bfha_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 cfg_tvalid,
  output logic                 cfg_tready,
  input  bfha_pkg::dp_status_t status,
  output bfha_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_RD, S_EVAL, S_NEVAL, S_WRA, S_WRB, S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] code_r, code_nxt;

  assign in_tready  = (state_r == S_IDLE) && !cfg_tvalid;
  assign cfg_tready = (state_r == S_IDLE);

  // next state and command
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd.op    = bfha_pkg::CMD_NOP;
    cmd.code  = code_r;
    case (state_r)
      S_INIT: begin
        cmd.op    = bfha_pkg::CMD_FORMAT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.op    = bfha_pkg::CMD_LOAD;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (status.is_alloc && status.zero_size) begin
          code_nxt  = bfha_pkg::RC_ZERO;
          state_nxt = S_FIN;
        end else if (!status.is_alloc && status.bad_early) begin
          code_nxt  = bfha_pkg::RC_BAD;
          state_nxt = S_FIN;
        end else if (status.walk_end) begin
          if (status.is_alloc && status.have_best) begin
            state_nxt = S_WRA;
          end else begin
            code_nxt  = status.is_alloc ? bfha_pkg::RC_NOFIT : bfha_pkg::RC_BAD;
            state_nxt = S_FIN;
          end
        end else if (!status.is_alloc && status.past_tgt) begin
          code_nxt  = bfha_pkg::RC_BAD;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = bfha_pkg::CMD_RD_OFF;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.is_alloc) begin
          cmd.op    = bfha_pkg::CMD_STEP;
          state_nxt = status.hit_exact ? S_WRA : S_RD;
        end else if (status.found) begin
          if (status.tgt_alloc) begin
            cmd.op    = bfha_pkg::CMD_RD_NXT;
            state_nxt = S_NEVAL;
          end else begin
            code_nxt  = bfha_pkg::RC_BAD;
            state_nxt = S_FIN;
          end
        end else begin
          cmd.op    = bfha_pkg::CMD_STEP;
          state_nxt = S_RD;
        end
      end
      S_NEVAL: begin
        cmd.op    = bfha_pkg::CMD_LATCH_NXT;
        state_nxt = S_WRA;
      end
      S_WRA: begin
        cmd.op    = bfha_pkg::CMD_WR_A;
        code_nxt  = bfha_pkg::RC_OK;
        state_nxt = (status.is_alloc && status.split) ? S_WRB : S_FIN;
      end
      S_WRB: begin
        cmd.op    = bfha_pkg::CMD_WR_B;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!status.out_busy) begin
          cmd.op    = bfha_pkg::CMD_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      code_r  <= bfha_pkg::RC_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  // result only issued into a free output register
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == bfha_pkg::CMD_FINISH) |-> !status.out_busy)
    else $error("finish while output busy");

  // no request taken while a configuration write is pending
  a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tready && cfg_tvalid) |-> 1'b0)
    else $error("request accepted during config write");

endmodule

>>> rtl/bfha_dp.sv
// ----------------------------------------------------------------------------
// bfha_dp: datapath of the allocator
// Chunk map memory, walk registers, best-fit tracking, merge arithmetic,
// free chunk counter and the result register.
// ----------------------------------------------------------------------------
module bfha_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          in_tdata,
  input  logic [0:0]           in_tuser,
  input  logic                 cfg_we,
  input  logic [16:0]          cfg_data,
  input  bfha_pkg::ctl_cmd_t   cmd,
  output bfha_pkg::dp_status_t status,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [47:0]          out_tdata,
  output logic [1:0]           out_tuser
);

  localparam int unsigned AW = bfha_pkg::ADDR_W;
  localparam int unsigned SW = bfha_pkg::SZW;
  localparam int unsigned CW = bfha_pkg::CNT_W;

  // chunk map: {status, size in words}
  logic [SW+1:0] mem [bfha_pkg::MAP_DEPTH];
  logic [SW+1:0] rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [SW+1:0] mem_wdata;

  logic [SW-1:0] heap_w_r;
  logic [CW-1:0] free_cnt_r;
  logic          out_valid_r;
  logic [1:0]    out_code_r;
  logic [15:0]   out_pay_r;
  logic [16:0]   out_bytes_r;
  logic [CW-1:0] out_cnt_r;

  logic          op_r;
  logic [15:0]   req_r, doff_r;
  logic [SW-1:0] need_r, off_r, bsz_r, psz_r, tsz_r, nsz_r, fin_r;
  logic [AW-1:0] tgt_r, best_r, prev_r;
  logic          have_best_r, pfree_r, nin_r, nfree_r;

  logic [SW-1:0] rd_sz, merged, nxt_w, fit_w;
  logic [1:0]    rd_st;
  logic [16:0]   req_up;
  logic [15:0]   cfg_up;
  logic [15:0]   split_lim;

  assign rd_sz = rdata_r[SW-1:0];
  assign rd_st = rdata_r[SW+1:SW];
  assign req_up = {1'b0, in_tdata[15:0]} + 17'd3;
  assign nxt_w  = {1'b0, tgt_r} + rd_sz;
  assign merged = tsz_r + (nfree_r ? nsz_r : '0);
  assign split_lim = {1'b0, need_r} + 16'(bfha_pkg::SPLIT_WORDS);

  // heap size in words from a configuration value
  always_comb begin
    cfg_up = 16'(({1'b0, cfg_data} + 18'd3) >> 2);
    if (cfg_up < {1'b0, bfha_pkg::MIN_HEAP_W})      fit_w = bfha_pkg::MIN_HEAP_W;
    else if (cfg_up > {1'b0, bfha_pkg::MAX_HEAP_W}) fit_w = bfha_pkg::MAX_HEAP_W;
    else                                            fit_w = cfg_up[SW-1:0];
  end

  // status to the controller
  always_comb begin
    status.is_alloc  = (op_r == bfha_pkg::OP_ALLOC);
    status.zero_size = (req_r == '0);
    status.bad_early = (doff_r < 16'd8) || (doff_r[1:0] != 2'b00);
    status.walk_end  = (off_r >= heap_w_r);
    status.past_tgt  = (off_r > {1'b0, tgt_r});
    status.hit_exact = (rd_st == bfha_pkg::ST_FREE) && (rd_sz == need_r);
    status.found     = (off_r == {1'b0, tgt_r});
    status.tgt_alloc = (rd_st == bfha_pkg::ST_ALLOC);
    status.have_best = have_best_r;
    status.split     = ({1'b0, bsz_r} >= split_lim);
    status.out_busy  = out_valid_r && !out_tready;
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = {bfha_pkg::ST_FREE, heap_w_r};
    mem_raddr = (cmd.op == bfha_pkg::CMD_RD_NXT) ? nxt_w[AW-1:0] : off_r[AW-1:0];
    if (cfg_we) begin
      mem_we    = 1'b1;
      mem_wdata = {bfha_pkg::ST_FREE, fit_w};
    end else begin
      case (cmd.op)
        bfha_pkg::CMD_FORMAT: mem_we = 1'b1;
        bfha_pkg::CMD_WR_A: begin
          mem_we = 1'b1;
          if (op_r == bfha_pkg::OP_ALLOC) begin
            if (status.split) begin
              mem_waddr = AW'({1'b0, best_r} + need_r);
              mem_wdata = {bfha_pkg::ST_FREE, bsz_r - need_r};
            end else begin
              mem_waddr = best_r;
              mem_wdata = {bfha_pkg::ST_ALLOC, bsz_r};
            end
          end else if (pfree_r) begin
            mem_waddr = prev_r;
            mem_wdata = {bfha_pkg::ST_FREE, psz_r + merged};
          end else begin
            mem_waddr = tgt_r;
            mem_wdata = {bfha_pkg::ST_FREE, merged};
          end
        end
        bfha_pkg::CMD_WR_B: begin
          mem_we    = 1'b1;
          mem_waddr = best_r;
          mem_wdata = {bfha_pkg::ST_ALLOC, need_r};
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  // chunk map memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  // control registers: heap size, free count, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_w_r    <= bfha_pkg::MIN_HEAP_W;
      free_cnt_r  <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        heap_w_r   <= fit_w;
        free_cnt_r <= CW'(1);
      end else begin
        case (cmd.op)
          bfha_pkg::CMD_FORMAT: free_cnt_r <= CW'(1);
          bfha_pkg::CMD_WR_A: begin
            if (op_r == bfha_pkg::OP_ALLOC) begin
              if (!status.split) free_cnt_r <= free_cnt_r - CW'(1);
            end else begin
              free_cnt_r <= free_cnt_r + CW'(1) - CW'(nfree_r) - CW'(pfree_r);
            end
          end
          bfha_pkg::CMD_FINISH: out_valid_r <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // walk and result payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      bfha_pkg::CMD_LOAD: begin
        op_r        <= in_tuser[0];
        req_r       <= in_tdata[15:0];
        doff_r      <= in_tdata[31:16];
        need_r      <= SW'(req_up >> 2) + SW'(bfha_pkg::HDR_WORDS);
        tgt_r       <= AW'((in_tdata[31:16] - 16'd8) >> 2);
        off_r       <= '0;
        bsz_r       <= '1;
        have_best_r <= 1'b0;
        pfree_r     <= 1'b0;
      end
      bfha_pkg::CMD_STEP: begin
        if (op_r == bfha_pkg::OP_ALLOC) begin
          if (rd_st == bfha_pkg::ST_FREE && (rd_sz == need_r ||
              (rd_sz > need_r && rd_sz <= bsz_r))) begin
            best_r      <= off_r[AW-1:0];
            bsz_r       <= rd_sz;
            have_best_r <= 1'b1;
          end
        end else begin
          prev_r   <= off_r[AW-1:0];
          psz_r    <= rd_sz;
          pfree_r  <= (rd_st == bfha_pkg::ST_FREE);
        end
        off_r <= off_r + rd_sz;
      end
      bfha_pkg::CMD_RD_NXT: begin
        tsz_r <= rd_sz;
        nin_r <= (nxt_w < heap_w_r);
      end
      bfha_pkg::CMD_LATCH_NXT: begin
        nfree_r <= nin_r && (rd_st == bfha_pkg::ST_FREE);
        nsz_r   <= rd_sz;
      end
      bfha_pkg::CMD_WR_A: begin
        if (op_r == bfha_pkg::OP_ALLOC) fin_r <= status.split ? need_r : bsz_r;
        else                            fin_r <= pfree_r ? (psz_r + merged) : merged;
      end
      bfha_pkg::CMD_FINISH: begin
        out_code_r <= cmd.code;
        out_cnt_r  <= free_cnt_r;
        if (cmd.code == bfha_pkg::RC_OK) begin
          out_pay_r   <= (op_r == bfha_pkg::OP_ALLOC) ? ({best_r, 2'b00} + 16'd8) : '0;
          out_bytes_r <= {fin_r, 2'b00};
        end else begin
          out_pay_r   <= '0;
          out_bytes_r <= '0;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_code_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_bytes_r, out_pay_r};

  // free count stays within what the heap can hold
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= bfha_pkg::MAX_FREE)
    else $error("free chunk count out of range");

  // heap size always inside its legal window
  a_heap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (heap_w_r >= bfha_pkg::MIN_HEAP_W) && (heap_w_r <= bfha_pkg::MAX_HEAP_W))
    else $error("heap size out of range");

  // the walk always moves forward
  a_walk_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == bfha_pkg::CMD_STEP) |=> (off_r > $past(off_r)))
    else $error("chunk walk did not advance");

endmodule
